// ===== sv/lkvc_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
// Holds payload widths, the controller state type and the per-cell control struct.
// No dependencies.
package lkvc_pkg;

    localparam int CAPACITY_DEFAULT  = 16;
    localparam int KEY_WIDTH_DEFAULT = 16;

    localparam int OPCODE_W = 1;
    localparam int KEY_IN_W = 16;
    localparam int VALUE_W  = 31;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam logic [OPCODE_W-1:0] OP_GET = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic capture;   // latch the compare result
        logic update;    // apply the shift this cycle
        logic hit;       // the item's key is present
        logic put;       // the item is a put
    } cell_ctrl_t;

endpackage

// ===== sv/lkvc_req_if.sv =====
// Request channel of the LRU key/value cache: valid/ready plus the item fields.
// Depends on lkvc_pkg.
interface lkvc_req_if
    import lkvc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_IN_W-1:0] lookup_key;
    logic [VALUE_W-1:0]  store_value;

    modport source (output valid, output opcode, output lookup_key, output store_value,
                    input ready);
    modport sink   (input valid, input opcode, input lookup_key, input store_value,
                    output ready);
endinterface

// ===== sv/lkvc_rsp_if.sv =====
// Response channel of the LRU key/value cache: valid/ready plus the result fields.
// Depends on lkvc_pkg.
interface lkvc_rsp_if
    import lkvc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [VALUE_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ===== sv/lkvc_cell.sv =====
// One entry of the recency-ordered chain: key, value, valid, and the latched match.
// Position in the chain is the recency rank; entries shift from the neighbor below.
// Depends on lkvc_pkg.
module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT,
    parameter int LIM_W     = 5,
    parameter int INDEX     = 0
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic [LIM_W-1:0]     limit,
    input  logic [KEY_WIDTH-1:0] cmp_key,
    input  logic                 nb_valid,
    input  logic [KEY_WIDTH-1:0] nb_key,
    input  logic [VALUE_W-1:0]   nb_value,
    input  logic                 suffix_in,
    output logic                 valid,
    output logic [KEY_WIDTH-1:0] key,
    output logic [VALUE_W-1:0]   value,
    output logic                 match,
    output logic [VALUE_W-1:0]   match_value,
    output logic                 suffix_out
);

    logic                 valid_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic                 match_reg;
    logic                 shift;

    assign match       = valid_reg && (key_reg == cmp_key);
    assign match_value = match ? value_reg : '0;

    // set for the hit cell and every cell nearer the head of the chain (lower index)
    assign suffix_out  = match_reg | suffix_in;

    always_comb
    begin
        if (ctrl.hit)
        begin
            shift = ctrl.update && suffix_out;
        end
        else
        begin
            shift = ctrl.update && ctrl.put && (LIM_W'(INDEX) < limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.capture)
            begin
                match_reg <= match;
            end
            if (shift)
            begin
                valid_reg <= nb_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= nb_key;
            value_reg <= nb_value;
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Top level of the LRU key/value cache: controller, occupancy, and the cell chain.
// Depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if and lkvc_cell.
//
// Usage:
//   req carries items {opcode, lookup_key, store_value}; opcode 0 is a get, 1 a put.
//   rsp carries {hit, read_value}, one item per get and none per put; a miss
//   returns hit = 0 and read_value = 0.
//   cfg_we / cfg_wdata write active_capacity (0 acts as 1, above CAPACITY saturates);
//   write it only while the block is idle.
// Timing:
//   An item is taken in, compared against all cells in the lookup state, and the
//   chain shifts in the update state, which is also when a get result is
//   registered onto rsp.
//   A new item is taken only as the previous one shifts, set by the
//   compare-then-shift sequence over the cell chain.
// Reset: all entries invalid, occupancy zero, active_capacity 16. No clearing pass.
// Stall: a pending get result sits in the output register; a following put
//   proceeds, a following get waits in its shift cycle until rsp is taken.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEFAULT,
    parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    lkvc_req_if.sink         req,
    lkvc_rsp_if.source       rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LIM_W = $clog2(CAPACITY + 2);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     cfg_reg;
    logic [CNT_W-1:0]     occ_reg;
    logic [OPCODE_W-1:0]  op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic                 hit_reg;
    logic [VALUE_W-1:0]   hval_reg;

    logic                 rsp_valid_reg;
    logic                 rsp_hit_reg;
    logic [VALUE_W-1:0]   rsp_value_reg;

    logic                 accept;
    logic                 update_fire;
    logic                 rsp_load;
    cell_ctrl_t           ctrl;

    logic [CMP_W-1:0]     cfg_ext;
    logic [CMP_W-1:0]     cap_ext;
    logic [CMP_W-1:0]     eff_cap;
    logic                 full;
    logic [LIM_W-1:0]     limit;

    logic [VALUE_W-1:0]   front_value;
    logic                 hit_any;
    logic [VALUE_W-1:0]   hit_value;

    logic                 c_valid       [CAPACITY];
    logic [KEY_WIDTH-1:0] c_key         [CAPACITY];
    logic [VALUE_W-1:0]   c_value       [CAPACITY];
    logic                 c_match       [CAPACITY];
    logic [VALUE_W-1:0]   c_match_value [CAPACITY];
    logic                 c_suffix      [CAPACITY];

    // effective capacity and fullness
    always_comb
    begin
        cfg_ext = CMP_W'(cfg_reg);
        cap_ext = CMP_W'(CAPACITY);
        if (cfg_ext > cap_ext)
        begin
            eff_cap = cap_ext;
        end
        else if (cfg_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else
        begin
            eff_cap = cfg_ext;
        end
        full = (CMP_W'(occ_reg) >= eff_cap);
        // full: drop the last valid entry; otherwise the chain grows by one
        limit = full ? LIM_W'(occ_reg) : LIM_W'(occ_reg) + LIM_W'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (update_fire)
                begin
                    state_next = req.valid ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        update_fire  = 1'b0;
        ctrl.capture = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                update_fire = 1'b0;
            end
            ST_LOOKUP:
            begin
                ctrl.capture = 1'b1;
            end
            ST_UPDATE:
            begin
                // a get waits while an earlier result is still unread
                update_fire = !((op_reg == OP_GET) && rsp_valid_reg && !rsp.ready);
            end
            default:
            begin
                update_fire = 1'b0;
            end
        endcase
        ctrl.update = update_fire;
        ctrl.hit    = hit_reg;
        ctrl.put    = (op_reg == OP_PUT);
        req.ready   = (state_reg == ST_IDLE) || update_fire;
        accept      = req.valid && req.ready;
        rsp_load    = update_fire && (op_reg == OP_GET);
        front_value = (op_reg == OP_PUT) ? val_reg : hval_reg;
    end

    // compare results gathered from all cells
    always_comb
    begin
        hit_any   = 1'b0;
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_any   = hit_any | c_match[i];
            hit_value = hit_value | c_match_value[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= CFG_RESET;
            occ_reg       <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (ctrl.capture)
            begin
                hit_reg <= hit_any;
            end
            if (update_fire && ctrl.put && !hit_reg && !full)
            begin
                occ_reg <= occ_reg + CNT_W'(1);
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.opcode;
            key_reg <= KEY_WIDTH'(req.lookup_key);
            val_reg <= req.store_value;
        end
        if (ctrl.capture)
        begin
            hval_reg <= hit_value;
        end
        if (rsp_load)
        begin
            rsp_hit_reg   <= hit_reg;
            rsp_value_reg <= hval_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                 nb_valid;
            logic [KEY_WIDTH-1:0] nb_key;
            logic [VALUE_W-1:0]   nb_value;
            logic                 sfx_in;

            if (g == 0)
            begin : g_head
                assign nb_valid = 1'b1;
                assign nb_key   = key_reg;
                assign nb_value = front_value;
            end
            else
            begin : g_body
                assign nb_valid = c_valid[g-1];
                assign nb_key   = c_key[g-1];
                assign nb_value = c_value[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign sfx_in = 1'b0;
            end
            else
            begin : g_link
                assign sfx_in = c_suffix[g+1];
            end

            lkvc_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .LIM_W     (LIM_W),
                .INDEX     (g)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .limit       (limit),
                .cmp_key     (key_reg),
                .nb_valid    (nb_valid),
                .nb_key      (nb_key),
                .nb_value    (nb_value),
                .suffix_in   (sfx_in),
                .valid       (c_valid[g]),
                .key         (c_key[g]),
                .value       (c_value[g]),
                .match       (c_match[g]),
                .match_value (c_match_value[g]),
                .suffix_out  (c_suffix[g])
            );
        end
    endgenerate

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = rsp_hit_reg;
    assign rsp.read_value = rsp_value_reg;

endmodule
